// File: src/tcl_pkg.sv
package tcl_pkg;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_LISTEN = 2'd1;

    localparam logic [1:0] OUT_WRITE_DONE = 2'd0;
    localparam logic [1:0] OUT_DELIVER    = 2'd1;
    localparam logic [1:0] OUT_RESET      = 2'd2;

    localparam logic MATCH_LISTEN = 1'b0;
    localparam logic MATCH_EXACT  = 1'b1;

    typedef struct packed {
        logic [63:0] local_hi;
        logic [63:0] local_lo;
        logic [63:0] remote_hi;
        logic [63:0] remote_lo;
        logic [15:0] local_port;
        logic [15:0] remote_port;
    } key_t;

    typedef struct packed {
        logic [1:0] kind;
        key_t       addr;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic listen_hit;
        logic exact_hit;
    } match_t;

    typedef struct packed {
        logic wr_en;
        logic key_load;
    } ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

// File: src/tcl_ram.sv
module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tcl_cmp.sv
module tcl_cmp (
    input  tcl_pkg::entry_t entry,
    input  logic            entry_valid,
    input  tcl_pkg::key_t   key,
    output tcl_pkg::match_t match
);

    logic [1:0] kind;
    logic       local_eq;
    logic       wild;
    logic       lport_eq;
    logic       remote_eq;

    always_comb begin
        kind      = entry_valid ? entry.kind : tcl_pkg::KIND_FREE;
        local_eq  = (entry.addr.local_hi == key.local_hi) &&
                    (entry.addr.local_lo == key.local_lo);
        wild      = (entry.addr.local_hi == 64'd0) && (entry.addr.local_lo == 64'd0);
        lport_eq  = entry.addr.local_port == key.local_port;
        remote_eq = (entry.addr.remote_hi == key.remote_hi) &&
                    (entry.addr.remote_lo == key.remote_lo) &&
                    (entry.addr.remote_port == key.remote_port);
        match = '0;
        case (kind)
            tcl_pkg::KIND_FREE: begin
                match = '0;
            end
            tcl_pkg::KIND_LISTEN: begin
                match.listen_hit = (wild || local_eq) && lport_eq;
            end
            default: begin
                match.exact_hit = local_eq && lport_eq && remote_eq;
            end
        endcase
    end

endmodule

// File: src/tcl_ctrl.sv
module tcl_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_mode,
    input  logic [3:0]                                 s_slot,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [1:0]                                 m_outcome,
    output logic [3:0]                                 m_found_slot,
    output logic                                       m_match_kind,
    output tcl_pkg::ctl_t                              ctl,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic                                       entry_valid,
    input  tcl_pkg::match_t                            match
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    tcl_pkg::state_t state_reg, state_next;

    logic [CW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      hit_reg, hit_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [1:0]         outcome_reg, outcome_next;
    logic [3:0]         slot_reg, slot_next;
    logic               kind_reg, kind_next;

    logic          accept;
    logic          issue;
    logic          last;
    logic          exact_now;
    logic          listen_now;
    logic          found_now;
    logic [AW-1:0] hit_now;
    logic [AW+3:0] slot_ext;
    logic [AW+3:0] hit_ext;
    logic          in_range;

    assign accept     = s_valid && s_ready;
    assign slot_ext   = {{AW{1'b0}}, s_slot};
    assign in_range   = slot_ext < (AW + 4)'(ENTRIES);
    assign issue      = (state_reg == tcl_pkg::ST_SCAN) && (idx_reg < CW'(ENTRIES));
    assign last       = cmp_valid_reg && (cmp_idx_reg == AW'(ENTRIES - 1));
    assign exact_now  = cmp_valid_reg && match.exact_hit;
    assign listen_now = cmp_valid_reg && match.listen_hit;
    assign found_now  = found_reg || listen_now || exact_now;
    assign hit_now    = (listen_now || exact_now) ? cmp_idx_reg : hit_reg;
    assign hit_ext    = {4'd0, hit_now};
    assign entry_valid = valid_reg[cmp_idx_reg];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcl_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_mode == tcl_pkg::MODE_WRITE) ?
                                 tcl_pkg::ST_RESP : tcl_pkg::ST_SCAN;
                end
            end
            tcl_pkg::ST_SCAN: begin
                if (exact_now || last) begin
                    state_next = tcl_pkg::ST_RESP;
                end
            end
            tcl_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = tcl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        cmp_idx_next   = idx_reg[AW-1:0];
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        hit_next       = hit_reg;
        valid_next     = valid_reg;
        outcome_next   = outcome_reg;
        slot_next      = slot_reg;
        kind_next      = kind_reg;
        ctl            = '0;
        wr_addr        = slot_ext[AW-1:0];
        rd_addr        = idx_reg[AW-1:0];
        s_ready        = (state_reg == tcl_pkg::ST_IDLE);
        m_valid        = (state_reg == tcl_pkg::ST_RESP);
        case (state_reg)
            tcl_pkg::ST_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    hit_next   = '0;
                    if (s_mode == tcl_pkg::MODE_WRITE) begin
                        ctl.wr_en    = in_range;
                        outcome_next = tcl_pkg::OUT_WRITE_DONE;
                        slot_next    = 4'd0;
                        kind_next    = tcl_pkg::MATCH_LISTEN;
                        if (in_range) begin
                            valid_next[slot_ext[AW-1:0]] = 1'b1;
                        end
                    end else begin
                        ctl.key_load = 1'b1;
                    end
                end
            end
            tcl_pkg::ST_SCAN: begin
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                cmp_valid_next = issue && !exact_now;
                found_next     = found_now;
                hit_next       = hit_now;
                if (exact_now || last) begin
                    if (found_now) begin
                        outcome_next = tcl_pkg::OUT_DELIVER;
                        slot_next    = hit_ext[3:0];
                        kind_next    = exact_now ? tcl_pkg::MATCH_EXACT : tcl_pkg::MATCH_LISTEN;
                    end else begin
                        outcome_next = tcl_pkg::OUT_RESET;
                        slot_next    = 4'd0;
                        kind_next    = tcl_pkg::MATCH_LISTEN;
                    end
                end
            end
            default: begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcl_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        outcome_reg <= outcome_next;
        slot_reg    <= slot_next;
        kind_reg    <= kind_next;
    end

    assign m_outcome    = outcome_reg;
    assign m_found_slot = slot_reg;
    assign m_match_kind = kind_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_lookup_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == tcl_pkg::MODE_LOOKUP) |=> (state_reg == tcl_pkg::ST_SCAN))
        else $error("lookup did not start a scan");

    a_write_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == tcl_pkg::MODE_WRITE) |=>
        (m_valid && m_outcome == tcl_pkg::OUT_WRITE_DONE))
        else $error("write did not answer in the next cycle");

    a_exact_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_kind == tcl_pkg::MATCH_EXACT) |->
        (m_outcome == tcl_pkg::OUT_DELIVER))
        else $error("exact match without delivery");

endmodule

// File: src/tcp_connection_lookup_unit.sv
// Channel   Ports              Direction   Beat carries
// s_        s_valid / s_ready  in          write entry or segment to look up
// m_        m_valid / m_ready  out         outcome, found slot, match kind
//
// A write beat stores the entry when the beat is taken, and the result is
// offered in the next cycle.
// For a lookup beat, the key is held and the table RAM's registered read port
// is filled first; then one entry per cycle goes through the single
// comparator until the last entry is compared, and an exact connected match
// ends the scan early.
// Reset clears one valid flop per slot, so the table reads as all free at
// once. s_ready stays low from the taken beat until the result beat is
// taken.
module tcp_connection_lookup_unit #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [3:0]  s_slot,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_local_ip_hi,
    input  logic [63:0] s_local_ip_lo,
    input  logic [63:0] s_remote_ip_hi,
    input  logic [63:0] s_remote_ip_lo,
    input  logic [15:0] s_local_port,
    input  logic [15:0] s_remote_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [3:0]  m_found_slot,
    output logic        m_match_kind
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    tcl_pkg::key_t   in_key;
    tcl_pkg::key_t   key_reg;
    tcl_pkg::entry_t wr_entry;
    tcl_pkg::entry_t rd_entry;
    tcl_pkg::ctl_t   ctl;
    tcl_pkg::match_t match;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            entry_valid;

    always_comb begin
        in_key.local_hi    = s_local_ip_hi;
        in_key.local_lo    = s_local_ip_lo;
        in_key.remote_hi   = s_remote_ip_hi;
        in_key.remote_lo   = s_remote_ip_lo;
        in_key.local_port  = s_local_port;
        in_key.remote_port = s_remote_port;
        wr_entry.kind      = s_kind;
        wr_entry.addr      = in_key;
    end

    always_ff @(posedge aclk) begin
        if (ctl.key_load) begin
            key_reg <= in_key;
        end
    end

    tcl_ram #(
        .WIDTH (tcl_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    tcl_cmp u_cmp (
        .entry       (rd_entry),
        .entry_valid (entry_valid),
        .key         (key_reg),
        .match       (match)
    );

    tcl_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_slot       (s_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_outcome    (m_outcome),
        .m_found_slot (m_found_slot),
        .m_match_kind (m_match_kind),
        .ctl          (ctl),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .entry_valid  (entry_valid),
        .match        (match)
    );

endmodule

// File: tb/tb_tcp_connection_lookup_unit.sv
module tb_tcp_connection_lookup_unit;

    localparam int SLOTS = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [1:0] KIND_CONN = 2'd2;
    localparam logic [1:0] KIND_ODD  = 2'd3;

    typedef struct packed {
        logic [1:0] outcome;
        logic [3:0] slot;
        logic       kind;
    } lookup_result_t;

    class lookup_scoreboard;
        logic [1:0]     kind_tab [SLOTS];
        tcl_pkg::key_t  key_tab [SLOTS];
        lookup_result_t pending_results [$];
        int errors;
        int writes;
        int exact_hits;
        int listen_hits;
        int resets_sent;

        function new();
            foreach (kind_tab[i]) begin
                kind_tab[i] = tcl_pkg::KIND_FREE;
                key_tab[i] = '0;
            end
            errors = 0;
            writes = 0;
            exact_hits = 0;
            listen_hits = 0;
            resets_sent = 0;
        endfunction

        function lookup_result_t resolve(tcl_pkg::key_t probe);
            lookup_result_t res;
            logic local_eq;
            logic wild;
            res.outcome = tcl_pkg::OUT_RESET;
            res.slot = 4'd0;
            res.kind = tcl_pkg::MATCH_LISTEN;
            for (int i = 0; i < SLOTS; i++) begin
                local_eq = key_tab[i].local_hi == probe.local_hi &&
                           key_tab[i].local_lo == probe.local_lo;
                wild = key_tab[i].local_hi == 64'd0 && key_tab[i].local_lo == 64'd0;
                if (kind_tab[i] == tcl_pkg::KIND_LISTEN) begin
                    if ((wild || local_eq) && key_tab[i].local_port == probe.local_port) begin
                        res.outcome = tcl_pkg::OUT_DELIVER;
                        res.slot = i[3:0];
                        res.kind = tcl_pkg::MATCH_LISTEN;
                    end
                end else if (kind_tab[i] != tcl_pkg::KIND_FREE) begin
                    if (key_tab[i] == probe) begin
                        res.outcome = tcl_pkg::OUT_DELIVER;
                        res.slot = i[3:0];
                        res.kind = tcl_pkg::MATCH_EXACT;
                        break;
                    end
                end
            end
            return res;
        endfunction

        function void note_input(logic mode, logic [3:0] slot, logic [1:0] kind,
                                 tcl_pkg::key_t key);
            lookup_result_t res;
            if (mode == tcl_pkg::MODE_WRITE) begin
                kind_tab[slot] = kind;
                key_tab[slot] = key;
                res.outcome = tcl_pkg::OUT_WRITE_DONE;
                res.slot = 4'd0;
                res.kind = tcl_pkg::MATCH_LISTEN;
                writes++;
            end else begin
                res = resolve(key);
                if (res.outcome == tcl_pkg::OUT_RESET) begin
                    resets_sent++;
                end else if (res.kind == tcl_pkg::MATCH_EXACT) begin
                    exact_hits++;
                end else begin
                    listen_hits++;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] outcome, logic [3:0] slot, logic kind);
            lookup_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, outcome %0d slot %0d kind %0d",
                         $time, outcome, slot, kind);
                return;
            end
            want = pending_results.pop_front();
            if (outcome !== want.outcome) begin
                errors++;
                $display("%0t: outcome expected %0d, actual %0d", $time, want.outcome, outcome);
            end
            if (slot !== want.slot) begin
                errors++;
                $display("%0t: found slot expected %0d, actual %0d", $time, want.slot, slot);
            end
            if (kind !== want.kind) begin
                errors++;
                $display("%0t: match kind expected %0d, actual %0d", $time, want.kind, kind);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [3:0]  s_slot;
    logic [1:0]  s_kind;
    logic [63:0] s_local_ip_hi;
    logic [63:0] s_local_ip_lo;
    logic [63:0] s_remote_ip_hi;
    logic [63:0] s_remote_ip_lo;
    logic [15:0] s_local_port;
    logic [15:0] s_remote_port;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_outcome;
    logic [3:0]  m_found_slot;
    logic        m_match_kind;

    lookup_scoreboard sb = new();
    bit               calm = 1'b0;
    logic [1:0]       shadow_kind [SLOTS];
    tcl_pkg::key_t    shadow_key [SLOTS];
    logic [127:0]     addr_pool [4];
    logic [15:0]      port_pool [4];

    tcp_connection_lookup_unit #(.ENTRIES(SLOTS)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_slot         (s_slot),
        .s_kind         (s_kind),
        .s_local_ip_hi  (s_local_ip_hi),
        .s_local_ip_lo  (s_local_ip_lo),
        .s_remote_ip_hi (s_remote_ip_hi),
        .s_remote_ip_lo (s_remote_ip_lo),
        .s_local_port   (s_local_port),
        .s_remote_port  (s_remote_port),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_outcome      (m_outcome),
        .m_found_slot   (m_found_slot),
        .m_match_kind   (m_match_kind)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_mode, s_slot, s_kind,
                              {s_local_ip_hi, s_local_ip_lo, s_remote_ip_hi,
                               s_remote_ip_lo, s_local_port, s_remote_port});
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_outcome, m_found_slot, m_match_kind);
            end
        end
    end

    function automatic tcl_pkg::key_t random_key(input bit wide);
        tcl_pkg::key_t k;
        logic [127:0] a;
        logic [127:0] b;
        a = addr_pool[$urandom_range(3)];
        b = addr_pool[$urandom_range(3)];
        k.local_hi = a[127:64];
        k.local_lo = a[63:0];
        k.remote_hi = b[127:64];
        k.remote_lo = b[63:0];
        k.local_port = port_pool[$urandom_range(3)];
        k.remote_port = port_pool[$urandom_range(3)];
        if (wide) begin
            k = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        return k;
    endfunction

    task automatic send_item(input logic mode, input logic [3:0] slot,
                             input logic [1:0] kind, input tcl_pkg::key_t key);
        if (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        if (mode == tcl_pkg::MODE_WRITE) begin
            shadow_kind[slot] = kind;
            shadow_key[slot] = key;
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_slot         <= slot;
        s_kind         <= kind;
        s_local_ip_hi  <= key.local_hi;
        s_local_ip_lo  <= key.local_lo;
        s_remote_ip_hi <= key.remote_hi;
        s_remote_ip_lo <= key.remote_lo;
        s_local_port   <= key.local_port;
        s_remote_port  <= key.remote_port;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        tcl_pkg::key_t ka;
        tcl_pkg::key_t kb;
        tcl_pkg::key_t ones;
        tcl_pkg::key_t probe;
        tcl_pkg::key_t other;
        int roll;
        int pick;
        int bitpos;
        int guard;
        logic [1:0] kind;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_mode         <= tcl_pkg::MODE_LOOKUP;
        s_slot         <= 4'd0;
        s_kind         <= tcl_pkg::KIND_FREE;
        s_local_ip_hi  <= 64'd0;
        s_local_ip_lo  <= 64'd0;
        s_remote_ip_hi <= 64'd0;
        s_remote_ip_lo <= 64'd0;
        s_local_port   <= 16'd0;
        s_remote_port  <= 16'd0;
        m_ready        <= 1'b0;
        foreach (shadow_kind[i]) begin
            shadow_kind[i] = tcl_pkg::KIND_FREE;
            shadow_key[i] = '0;
        end
        addr_pool[0] = '1;
        for (int i = 1; i < 4; i++) begin
            addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        end
        port_pool[0] = 16'd80;
        port_pool[1] = 16'd443;
        port_pool[2] = 16'($urandom);
        port_pool[3] = 16'($urandom);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, wildcard and bound listeners, exact hits that end
        // the scan, a kind three entry, clearing a slot and all-zero/all-one keys.
        ones = '1;
        ka = {64'h2001_0db8_0000_0001, 64'h0000_0000_0000_0010,
              64'h2001_0db8_00aa_0000, 64'h0000_0000_0000_0099, 16'd80, 16'd5000};
        kb = ka;
        kb.local_lo = 64'h20;
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, '0);
        send_item(tcl_pkg::MODE_LOOKUP, 4'hf, KIND_ODD, ones);
        probe = '0;
        probe.local_port = 16'd80;
        send_item(tcl_pkg::MODE_WRITE, 4'd0, tcl_pkg::KIND_LISTEN, probe);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, kb);
        probe = kb;
        probe.local_port = 16'd81;
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, probe);
        probe = random_key(1'b1);
        probe.local_hi = ka.local_hi;
        probe.local_lo = ka.local_lo;
        probe.local_port = ka.local_port;
        send_item(tcl_pkg::MODE_WRITE, 4'd5, tcl_pkg::KIND_LISTEN, probe);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, ka);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, kb);
        send_item(tcl_pkg::MODE_WRITE, 4'd3, KIND_CONN, ka);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, ka);
        probe = ka;
        probe.remote_port = 16'd5001;
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, probe);
        send_item(tcl_pkg::MODE_WRITE, 4'hf, KIND_ODD, ones);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, ones);
        send_item(tcl_pkg::MODE_WRITE, 4'd3, tcl_pkg::KIND_FREE, ka);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, ka);
        send_item(tcl_pkg::MODE_WRITE, 4'hf, tcl_pkg::KIND_LISTEN, ones);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, ones);
        send_item(tcl_pkg::MODE_WRITE, 4'd12, KIND_CONN, '0);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, '0);
        send_item(tcl_pkg::MODE_WRITE, 4'd0, tcl_pkg::KIND_FREE, '0);
        send_item(tcl_pkg::MODE_LOOKUP, 4'd0, tcl_pkg::KIND_FREE, kb);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 700 && n < 1050);
            if (n % 400 == 399) begin
                drain_results();
            end
            roll = $urandom_range(99);
            if (roll < 30) begin
                pick = $urandom_range(99);
                kind = pick < 10 ? tcl_pkg::KIND_FREE : pick < 45 ? tcl_pkg::KIND_LISTEN :
                       pick < 90 ? KIND_CONN : KIND_ODD;
                probe = random_key($urandom_range(99) < 10);
                if (kind == tcl_pkg::KIND_LISTEN && $urandom_range(99) < 30) begin
                    probe.local_hi = 64'd0;
                    probe.local_lo = 64'd0;
                end
                send_item(tcl_pkg::MODE_WRITE, 4'($urandom), kind, probe);
            end else begin
                if (roll < 75) begin
                    pick = $urandom_range(SLOTS - 1);
                    probe = shadow_key[pick];
                    if (shadow_kind[pick] == tcl_pkg::KIND_LISTEN) begin
                        other = random_key(1'b0);
                        probe.remote_hi = other.remote_hi;
                        probe.remote_lo = other.remote_lo;
                        probe.remote_port = other.remote_port;
                        if (probe.local_hi == 64'd0 && probe.local_lo == 64'd0) begin
                            probe.local_hi = other.local_hi;
                            probe.local_lo = other.local_lo;
                        end
                    end
                    if ($urandom_range(99) < 20) begin
                        bitpos = $urandom_range($bits(tcl_pkg::key_t) - 1);
                        probe[bitpos] = ~probe[bitpos];
                    end
                end else begin
                    probe = random_key(roll >= 92);
                end
                send_item(tcl_pkg::MODE_LOOKUP, 4'($urandom), 2'($urandom), probe);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (sb.pending_results.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
        if (sb.pending_results.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_results.size());
        end
        $display("Run covered %0d table writes and %0d lookups.", sb.writes,
                 sb.exact_hits + sb.listen_hits + sb.resets_sent);
        $display("Lookups gave %0d exact hits, %0d listener hits and %0d resets.",
                 sb.exact_hits, sb.listen_hits, sb.resets_sent);
        if (sb.errors == 0) begin
            $display("** tcp_connection_lookup_unit: PASSED **");
        end else begin
            $display("** tcp_connection_lookup_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("%0t: run timed out", $time);
        $display("** tcp_connection_lookup_unit: FAILED **");
        $finish;
    end

endmodule

// File: tcp_connection_lookup_unit.f
src/tcl_pkg.sv
src/tcl_ram.sv
src/tcl_cmp.sv
src/tcl_ctrl.sv
src/tcp_connection_lookup_unit.sv
tb/tb_tcp_connection_lookup_unit.sv
